### hw/rtl/aesbcm_pkg.sv
// Shared types, constants and functions for the AES block cipher modes unit.
package aesbcm_pkg;

  localparam int NumKeyWords = 60;
  localparam int KwAddrW = 6;
  // Round key store: one 128-bit entry per round key
  localparam int RkDepth = 16;

  // Configuration register indexes
  localparam logic [2:0] RegKey0 = 3'd0;
  localparam logic [2:0] RegKey1 = 3'd1;
  localparam logic [2:0] RegKey2 = 3'd2;
  localparam logic [2:0] RegKey3 = 3'd3;
  localparam logic [2:0] RegIvHi = 3'd4;
  localparam logic [2:0] RegIvLo = 3'd5;
  localparam logic [2:0] RegKeySize = 3'd6;
  localparam logic [2:0] RegMode = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND,
    ST_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       exp_start;
    logic       exp_step;
    logic       load;
    logic       round;
    logic       finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic exp_done;
    logic last_round;
  } sts_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = a[7] ? ((a << 1) ^ 8'h1B) : (a << 1);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h00;
    p = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ p;
      p = xt(p);
    end
    gmul = r;
  endfunction

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic [7:0] ISBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Mix one column with coefficients m0..m3 (row 0 form).
  function automatic logic [31:0] mix_col(input logic [31:0] a, input logic [7:0] m0,
                                          input logic [7:0] m1, input logic [7:0] m2,
                                          input logic [7:0] m3);
    logic [7:0] a0, a1, a2, a3;
    a0 = a[31:24]; a1 = a[23:16]; a2 = a[15:8]; a3 = a[7:0];
    mix_col = {gmul(a0, m0) ^ gmul(a1, m1) ^ gmul(a2, m2) ^ gmul(a3, m3),
               gmul(a0, m3) ^ gmul(a1, m0) ^ gmul(a2, m1) ^ gmul(a3, m2),
               gmul(a0, m2) ^ gmul(a1, m3) ^ gmul(a2, m0) ^ gmul(a3, m1),
               gmul(a0, m1) ^ gmul(a1, m2) ^ gmul(a2, m3) ^ gmul(a3, m0)};
  endfunction

endpackage

### hw/rtl/aesbcm_ctrl.sv
// Controller state machine: key expansion, block rounds and result handoff.
module aesbcm_ctrl import aesbcm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   cfg_write,
  input  logic   in_beat,
  input  logic   out_free,
  input  sts_t   sts,
  output logic   busy,
  output cmd_t   cmd
);

  state_t state, state_next;
  logic   keys_ready;

  // Track whether the schedule matches the current configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      keys_ready <= 1'b0;
    end else if (cfg_write) begin
      keys_ready <= 1'b0;
    end else if (state == ST_EXPAND && sts.exp_done) begin
      keys_ready <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_beat) state_next = keys_ready ? ST_LOAD : ST_EXPAND;
      ST_EXPAND: if (sts.exp_done) state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_ROUND;
      ST_ROUND:  if (sts.last_round) state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        cmd.exp_start = in_beat && !keys_ready;
      end
      ST_EXPAND: cmd.exp_step = 1'b1;
      ST_LOAD:   cmd.load = 1'b1;
      ST_ROUND:  cmd.round = 1'b1;
      ST_OUT:    cmd.finish = out_free;
      default:   cmd = '0;
    endcase
  end

  ast_round_after_load: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |=> state == ST_ROUND) else $error("load not followed by round");
  ast_idle_no_cmd: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !cmd.round && !cmd.load) else $error("command while idle");
  ast_ready_after_exp: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXPAND && sts.exp_done && !cfg_write) |=> keys_ready)
    else $error("keys not marked ready");

endmodule

### hw/rtl/aesbcm_datapath.sv
// Datapath: key schedule store, round unit, CBC chain and result register.
module aesbcm_datapath import aesbcm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          cmd,
  input  logic          in_beat,
  input  logic [128:0]  in_data,
  input  logic [255:0]  key,
  input  logic [127:0]  iv,
  input  logic [1:0]    key_size,
  input  logic [1:0]    cipher_mode,
  output sts_t          sts,
  output logic [127:0]  result
);

  logic [127:0]       rk_mem [RkDepth];
  logic [KwAddrW-1:0] exp_idx;
  logic [3:0]         exp_sub;
  logic [2:0]         exp_mod;
  logic [7:0]         rcon;
  logic [31:0]        w1, w2, w3, w4, w5, w6, w7, w8;
  logic [3:0]         nk;
  logic [KwAddrW-1:0] total;
  logic [3:0]         nr;
  logic [3:0]         rnd;
  logic [127:0]       st;
  logic [127:0]       blk;
  logic               first;
  logic [127:0]       chain;
  logic               cbc, dec;
  logic [3:0]         rk_round;
  logic [127:0]       rk;
  logic [127:0]       rk_dec;
  logic [31:0]        t_word;
  logic [31:0]        new_word;
  logic               wr_en;
  logic [KwAddrW-1:0] wr_addr;
  logic [31:0]        wr_word;
  logic [127:0]       sb, sr, mc, nxt;
  logic [127:0]       isr, isb, imc_in;

  assign cbc = cipher_mode[1];
  assign dec = cipher_mode[0];
  assign nk = (key_size == 2'd0) ? 4'd4 : ((key_size == 2'd1) ? 4'd6 : 4'd8);
  assign nr = nk + 4'd6;
  assign total = (key_size == 2'd0) ? 6'd44 : ((key_size == 2'd1) ? 6'd52 : 6'd60);

  // Expansion: keep a window of the last eight words in registers
  always_comb begin
    t_word = w1;
    if (exp_mod == 3'd0) begin
      t_word = sub_word({w1[23:0], w1[31:24]}) ^ {rcon, 24'h0};
    end else if (nk == 4'd8 && exp_mod == 3'd4) begin
      t_word = sub_word(w1);
    end
    case (nk)
      4'd4:    new_word = w4 ^ t_word;
      4'd6:    new_word = w6 ^ t_word;
      default: new_word = w8 ^ t_word;
    endcase
  end

  assign sts.exp_done = (exp_idx == total);

  // Select the schedule word written this cycle: key words first, then derived words
  always_comb begin
    wr_en = 1'b0;
    wr_addr = exp_idx;
    wr_word = new_word;
    if (cmd.exp_step) begin
      if (exp_sub != nk) begin
        wr_en = 1'b1;
        wr_addr = 6'(exp_sub);
        case (exp_sub[2:0])
          3'd0:    wr_word = key[255:224];
          3'd1:    wr_word = key[223:192];
          3'd2:    wr_word = key[191:160];
          3'd3:    wr_word = key[159:128];
          3'd4:    wr_word = key[127:96];
          3'd5:    wr_word = key[95:64];
          3'd6:    wr_word = key[63:32];
          default: wr_word = key[31:0];
        endcase
      end else if (!sts.exp_done) begin
        wr_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exp_start) begin
      exp_idx <= 6'(nk);
      exp_sub <= 4'd0;
      exp_mod <= 3'd0;
      rcon <= 8'h01;
      {w1, w2, w3, w4, w5, w6, w7, w8} <= (nk == 4'd4) ? {key[159:128], key[191:160],
        key[223:192], key[255:224], 128'h0} : (nk == 4'd6) ? {key[95:64], key[127:96],
        key[159:128], key[191:160], key[223:192], key[255:224], 64'h0} :
        {key[31:0], key[63:32], key[95:64], key[127:96], key[159:128], key[191:160],
         key[223:192], key[255:224]};
    end else if (cmd.exp_step) begin
      // First store the key words, then compute one word a cycle
      if (exp_sub != nk) begin
        exp_sub <= exp_sub + 4'd1;
      end else if (!sts.exp_done) begin
        {w1, w2, w3, w4, w5, w6, w7, w8} <= {new_word, w1, w2, w3, w4, w5, w6, w7};
        exp_idx <= exp_idx + 6'd1;
        exp_mod <= (exp_mod == 3'(nk - 4'd1)) ? 3'd0 : exp_mod + 3'd1;
        if (exp_mod == 3'd0) rcon <= xt(rcon);
      end
    end
  end

  // Round key for the next cycle: the load key while waiting, then one round ahead
  assign rk_round = cmd.load ? (dec ? nr - 4'd1 : 4'd1) :
                    cmd.round ? (dec ? rnd - 4'd2 : rnd + 4'd2) : (dec ? nr : 4'd0);

  // Write one schedule word a cycle, read one round key a cycle into a register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (wr_addr[1:0])
        2'd0:    rk_mem[wr_addr[5:2]][127:96] <= wr_word;
        2'd1:    rk_mem[wr_addr[5:2]][95:64] <= wr_word;
        2'd2:    rk_mem[wr_addr[5:2]][63:32] <= wr_word;
        default: rk_mem[wr_addr[5:2]][31:0] <= wr_word;
      endcase
    end
    rk <= rk_mem[rk_round];
  end

  // Forward round
  always_comb begin
    for (int i = 0; i < 16; i++) sb[127-8*i -: 8] = SBOX[st[127-8*i -: 8]];
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        sr[127-8*(r+4*c) -: 8] = sb[127-8*(r+4*((c+r)%4)) -: 8];
    for (int c = 0; c < 4; c++)
      mc[127-32*c -: 32] = mix_col(sr[127-32*c -: 32], 8'h02, 8'h03, 8'h01, 8'h01);
    // Inverse round: shift, sub, key, then inverse mix
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        isr[127-8*(r+4*((c+r)%4)) -: 8] = st[127-8*(r+4*c) -: 8];
    for (int i = 0; i < 16; i++) isb[127-8*i -: 8] = ISBOX[isr[127-8*i -: 8]];
    imc_in = isb ^ rk;
    for (int c = 0; c < 4; c++)
      rk_dec[127-32*c -: 32] = mix_col(imc_in[127-32*c -: 32], 8'h0E, 8'h0B, 8'h0D, 8'h09);
    if (dec) begin
      nxt = (rnd == 4'd1) ? imc_in : rk_dec;
    end else begin
      nxt = ((rnd + 4'd1 == nr) ? sr : mc) ^ rk;
    end
  end

  assign sts.last_round = dec ? (rnd == 4'd1) : (rnd + 4'd1 == nr);

  // Capture the beat, run rounds, update chain and result
  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= '0;
    end else begin
      if (in_beat) begin
        blk <= in_data[127:0];
        first <= in_data[128];
      end
      if (cmd.load) begin
        if (cbc && first) chain <= iv;
        if (!dec && cbc) st <= blk ^ (first ? iv : chain) ^ rk;
        else st <= blk ^ rk;
        rnd <= dec ? nr : 4'd0;
      end else if (cmd.round) begin
        st <= nxt;
        rnd <= dec ? rnd - 4'd1 : rnd + 4'd1;
        if (sts.last_round) begin
          if (cbc && dec) begin
            result <= nxt ^ chain;
            chain <= blk;
          end else begin
            result <= nxt;
            if (cbc) chain <= nxt;
          end
        end
      end
    end
  end

  ast_exp_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.exp_step |-> exp_idx <= 6'(NumKeyWords)) else $error("expansion overrun");
  ast_rnd_range: assert property (@(posedge clk) disable iff (rst)
    cmd.round |-> rnd <= 4'd14) else $error("round counter out of range");
  ast_load_one: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.round)) else $error("load and round together");

endmodule

### hw/rtl/aes_block_cipher_modes_unit.sv
// Top level of the AES ECB/CBC block cipher unit.
// AES-128/192/256 in ECB or CBC mode, encrypt or decrypt, one 128-bit block
// per input beat. Configuration registers are written on the cfg channel
// (index 0..3 key, 4..5 IV, 6 key size, 7 mode); the user must write them
// only while the unit is idle, which the unit does not enforce. Any write
// forces the key schedule to be rebuilt before the next block.
// Input beat: s_tdata = {block_lo, block_hi}, s_tuser = first_block.
// Output beat: m_tdata = {result_lo, result_hi}.
// Each block takes a load step and then one round step per round (10, 12 or
// 14). The unit takes one block at a time, set by the single shared round
// unit and the CBC chain. After a configuration change, key expansion runs
// before the first block. Reset clears the chain, mode state and
// schedule-ready flag. A result waits in its register while m_tready is low;
// the next input beat can be taken in the cycle after that result is taken.
module aes_block_cipher_modes_unit import aesbcm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // block_hi[63:0], block_lo[127:64]
  input  logic         s_tuser,   // first_block
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // result_hi[63:0], result_lo[127:64]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  logic [63:0] key0, key1, key2, key3, iv_hi, iv_lo;
  logic [1:0]  key_size, cipher_mode;
  logic        cfg_write, in_beat, busy, out_valid;
  logic [127:0] result;
  cmd_t        cmd;
  sts_t        sts;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid;
  assign s_tready = !busy && !out_valid;
  assign in_beat = s_tvalid && s_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      {key0, key1, key2, key3, iv_hi, iv_lo} <= '0;
      key_size <= 2'd0;
      cipher_mode <= 2'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        RegKey0:    key0 <= cfg_data;
        RegKey1:    key1 <= cfg_data;
        RegKey2:    key2 <= cfg_data;
        RegKey3:    key3 <= cfg_data;
        RegIvHi:    iv_hi <= cfg_data;
        RegIvLo:    iv_lo <= cfg_data;
        RegKeySize: key_size <= cfg_data[1:0];
        RegMode:    cipher_mode <= cfg_data[1:0];
        default:    key0 <= key0;
      endcase
    end
  end

  // Hold the result until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.round && sts.last_round) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {result[63:0], result[127:64]};

  aesbcm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .in_beat(in_beat),
    .out_free(out_valid && m_tready), .sts(sts), .busy(busy), .cmd(cmd)
  );

  aesbcm_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_beat(in_beat),
    .in_data({s_tuser, s_tdata[63:0], s_tdata[127:64]}),
    .key({key0, key1, key2, key3}), .iv({iv_hi, iv_lo}),
    .key_size(key_size), .cipher_mode(cipher_mode), .sts(sts), .result(result)
  );

endmodule
